// File: design/plq_pkg.sv
// ----------------------------------------------------------------------------
// plq_pkg: shared types and constants for the price level order queue
// Operation and status codes, stream word layout, sequencer states and the
// control word that drives the shared aggregate unit.
// ----------------------------------------------------------------------------
package plq_pkg;

    // field widths
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned SLOT_W   = 8;
    localparam int unsigned PRICE_W  = 32;
    localparam int unsigned SHARE_W  = 32;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned COUNT_W  = 9;
    localparam int unsigned LSHARE_W = 40;
    localparam int unsigned VOL_W    = 64;

    // stream word layout
    localparam int unsigned S_TDATA_W = SLOT_W + PRICE_W + SHARE_W;
    localparam int unsigned M_FIELD_W = SLOT_W + SHARE_W + COUNT_W + LSHARE_W + VOL_W;
    localparam int unsigned M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
    localparam int unsigned M_PAD_W   = M_TDATA_W - M_FIELD_W;

    // operation kinds
    localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STS_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STS_PRICE      = 3'd1;
    localparam logic [STATUS_W-1:0] STS_EMPTY      = 3'd2;
    localparam logic [STATUS_W-1:0] STS_NOT_LISTED = 3'd3;
    localparam logic [STATUS_W-1:0] STS_LISTED     = 3'd4;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_LINK,
        ST_MUL,
        ST_ACC
    } t_state;

    // aggregate update kinds
    typedef enum logic [1:0] {
        VOP_NONE,
        VOP_ADD,
        VOP_SUB,
        VOP_CLEAR
    } t_vop;

    // control word for the aggregate unit
    typedef struct packed {
        logic                mul_en;
        logic                commit;
        t_vop                vop;
        logic [SHARE_W-1:0]  sh;
    } t_agg_ctl;

endpackage

// File: design/price_level_order_queue_top.sv
// ----------------------------------------------------------------------------
// price_level_order_queue_top: one price level of an order book
// Resting orders form a doubly linked queue over a pool of order slots held
// in link and share memories; push links at the head, pop takes the tail,
// remove unlinks any listed slot. Every word in gives one result word.
//
//   channel   dir  handshake                      contents
//   cfg       in   i_cfg_valid / o_cfg_ready      level price
//   s_axis    in   s_axis_tvalid / s_axis_tready  order operation
//   m_axis    out  m_axis_tvalid / m_axis_tready  status and aggregates
//
// Each word runs through accept, memory read, link update, multiply and
// accumulate steps; the registered link read and the shared multiplier
// need their own steps. The input is ready only in the idle state.
// A result waits in the output register while the next word is taken in;
// the accumulate step holds until that register is free.
// Synchronous active-low reset clears the queue, the listed bits and the
// level price; the link and share memories need no clearing.
// ----------------------------------------------------------------------------
module price_level_order_queue_top #(
    parameter int unsigned ORDER_SLOTS = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write: level price
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [plq_pkg::PRICE_W-1:0]     i_cfg_data,
    // operation stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [7:0] order_slot, [39:8] order_price, [71:40] order_shares
    input  logic [plq_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [1:0] kind
    input  logic [plq_pkg::KIND_W-1:0]      s_axis_tuser,
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] popped_slot, [39:8] popped_shares, [48:40] order_count,
    // [88:49] level_shares, [152:89] level_volume, [159:153] zero
    output logic [plq_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // [2:0] status
    output logic [plq_pkg::STATUS_W-1:0]    m_axis_tuser
);
    import plq_pkg::*;

    // slots reachable through an 8-bit slot field
    localparam int unsigned POOL = (ORDER_SLOTS < 256) ? ORDER_SLOTS : 256;
    localparam int unsigned SW   = $clog2(POOL);

    // slot reduction table: field value modulo the pool size
    logic [SW-1:0] w_slot_lut [256];
    for (genvar g = 0; g < 256; g++) begin : g_slot_lut
        localparam int unsigned SlotMod = g % ORDER_SLOTS;
        assign w_slot_lut[g] = SW'(SlotMod);
    end

    t_state              r_state, n_state;
    logic [KIND_W-1:0]   r_kind, n_kind;
    logic [SW-1:0]       r_slot, n_slot;
    logic [PRICE_W-1:0]  r_price, n_price;
    logic [SHARE_W-1:0]  r_shares_in, n_shares_in;
    logic [PRICE_W-1:0]  r_level_price;
    logic [SW-1:0]       r_head, n_head;
    logic [SW-1:0]       r_tail, n_tail;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [POOL-1:0]     r_listed, n_listed;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [SW-1:0]       r_pslot, n_pslot;
    logic [SHARE_W-1:0]  r_pshares, n_pshares;
    t_vop                r_vop, n_vop;
    logic [SHARE_W-1:0]  r_sh, n_sh;
    logic                r_out_valid, n_out_valid;
    logic [M_TDATA_W-1:0] r_out_data, n_out_data;
    logic [STATUS_W-1:0] r_out_user, n_out_user;

    // memory ports
    logic [SW-1:0]       w_raddr;
    logic [SW-1:0]       w_rd_next, w_rd_prev;
    logic [SHARE_W-1:0]  w_rd_share;
    logic                w_nx_we, w_pv_we, w_sh_we;
    logic [SW-1:0]       w_nx_waddr, w_nx_wdata;
    logic [SW-1:0]       w_pv_waddr, w_pv_wdata;

    // aggregate unit
    t_agg_ctl            w_agg_ctl;
    logic [LSHARE_W-1:0] w_agg_shares, w_agg_next_shares;
    logic [VOL_W-1:0]    w_agg_volume, w_agg_next_volume;

    // read the tail for pop, the named slot otherwise
    assign w_raddr = (r_kind == KIND_POP) ? r_tail : r_slot;

    plq_ram #(.WIDTH(SW), .DEPTH(POOL)) u_next_link (
        .i_clk   (i_clk),
        .i_we    (w_nx_we),
        .i_waddr (w_nx_waddr),
        .i_wdata (w_nx_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_next)
    );

    plq_ram #(.WIDTH(SW), .DEPTH(POOL)) u_prev_link (
        .i_clk   (i_clk),
        .i_we    (w_pv_we),
        .i_waddr (w_pv_waddr),
        .i_wdata (w_pv_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_prev)
    );

    plq_ram #(.WIDTH(SHARE_W), .DEPTH(POOL)) u_slot_shares (
        .i_clk   (i_clk),
        .i_we    (w_sh_we),
        .i_waddr (r_slot),
        .i_wdata (r_shares_in),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_share)
    );

    plq_agg u_agg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_agg_ctl),
        .i_level_price (r_level_price),
        .o_shares      (w_agg_shares),
        .o_volume      (w_agg_volume),
        .o_next_shares (w_agg_next_shares),
        .o_next_volume (w_agg_next_volume)
    );

    // sequencer: next state, link updates and result assembly
    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_slot      = r_slot;
        n_price     = r_price;
        n_shares_in = r_shares_in;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_listed    = r_listed;
        n_status    = r_status;
        n_pslot     = r_pslot;
        n_pshares   = r_pshares;
        n_vop       = r_vop;
        n_sh        = r_sh;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        w_nx_we     = 1'b0;
        w_nx_waddr  = r_slot;
        w_nx_wdata  = r_head;
        w_pv_we     = 1'b0;
        w_pv_waddr  = r_head;
        w_pv_wdata  = r_slot;
        w_sh_we     = 1'b0;
        w_agg_ctl   = '{mul_en: 1'b0, commit: 1'b0, vop: r_vop, sh: r_sh};

        // drop the result once taken
        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_kind      = s_axis_tuser;
                    n_slot      = w_slot_lut[s_axis_tdata[SLOT_W-1:0]];
                    n_price     = s_axis_tdata[SLOT_W +: PRICE_W];
                    n_shares_in = s_axis_tdata[SLOT_W+PRICE_W +: SHARE_W];
                    n_state     = ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_state = ST_LINK;
            end
            ST_LINK: begin
                n_status  = STS_OK;
                n_pslot   = '0;
                n_pshares = '0;
                n_vop     = VOP_NONE;
                n_sh      = w_rd_share;
                unique case (r_kind)
                    KIND_PUSH: begin
                        if (r_price != r_level_price) begin
                            n_status = STS_PRICE;
                        end else if (r_listed[r_slot]) begin
                            n_status = STS_LISTED;
                        end else begin
                            // link in at the head
                            w_nx_we = 1'b1;
                            w_sh_we = 1'b1;
                            if (r_count != '0) begin
                                w_pv_we = 1'b1;
                            end else begin
                                n_tail = r_slot;
                            end
                            n_head           = r_slot;
                            n_listed[r_slot] = 1'b1;
                            n_count          = r_count + COUNT_W'(1);
                            n_vop            = VOP_ADD;
                            n_sh             = r_shares_in;
                        end
                    end
                    KIND_POP: begin
                        if (r_count == '0) begin
                            n_status = STS_EMPTY;
                        end else begin
                            n_pslot          = r_tail;
                            n_pshares        = w_rd_share;
                            n_listed[r_tail] = 1'b0;
                            if (r_count > COUNT_W'(1)) begin
                                n_tail  = w_rd_prev;
                                n_count = r_count - COUNT_W'(1);
                                n_vop   = VOP_SUB;
                            end else begin
                                n_count = '0;
                                n_head  = '0;
                                n_tail  = '0;
                                n_vop   = VOP_CLEAR;
                            end
                        end
                    end
                    KIND_REMOVE: begin
                        if (!r_listed[r_slot] || r_count == '0) begin
                            n_status = STS_NOT_LISTED;
                        end else begin
                            n_listed[r_slot] = 1'b0;
                            if (r_count > COUNT_W'(1)) begin
                                if (r_slot == r_tail) begin
                                    n_tail = w_rd_prev;
                                end else if (r_slot == r_head) begin
                                    n_head = w_rd_next;
                                end else begin
                                    // bridge the neighbours
                                    w_nx_we    = 1'b1;
                                    w_nx_waddr = w_rd_prev;
                                    w_nx_wdata = w_rd_next;
                                    w_pv_we    = 1'b1;
                                    w_pv_waddr = w_rd_next;
                                    w_pv_wdata = w_rd_prev;
                                end
                                n_count = r_count - COUNT_W'(1);
                                n_vop   = VOP_SUB;
                            end else begin
                                n_count = '0;
                                n_head  = '0;
                                n_tail  = '0;
                                n_vop   = VOP_CLEAR;
                            end
                        end
                    end
                    default: begin
                        n_status = STS_OK;
                    end
                endcase
                n_state = ST_MUL;
            end
            ST_MUL: begin
                w_agg_ctl.mul_en = 1'b1;
                n_state          = ST_ACC;
            end
            ST_ACC: begin
                // hold until the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    w_agg_ctl.commit = 1'b1;
                    n_out_valid      = 1'b1;
                    n_out_user       = r_status;
                    n_out_data       = {{M_PAD_W{1'b0}}, w_agg_next_volume,
                                        w_agg_next_shares, r_count, r_pshares,
                                        SLOT_W'(r_pslot)};
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_head        <= '0;
            r_tail        <= '0;
            r_count       <= '0;
            r_listed      <= '0;
            r_out_valid   <= 1'b0;
            r_level_price <= '0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_listed    <= n_listed;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_level_price <= i_cfg_data;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_slot      <= n_slot;
        r_price     <= n_price;
        r_shares_in <= n_shares_in;
        r_status    <= n_status;
        r_pslot     <= n_pslot;
        r_pshares   <= n_pshares;
        r_vop       <= n_vop;
        r_sh        <= n_sh;
        r_out_data  <= n_out_data;
        r_out_user  <= n_out_user;
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // listed bits and the order count agree between words
    a_listed_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> ($countones(r_listed) == int'(r_count)))
        else $error("listed bits disagree with order count");

    // the count never exceeds the pool
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= COUNT_W'(POOL)))
        else $error("order count beyond pool size");

    // an empty level carries no shares and no volume
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && r_count == '0)
            |-> (w_agg_shares == '0 && w_agg_volume == '0))
        else $error("empty level with non-zero aggregates");

    // a blocked result holds the accumulate step
    a_acc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACC && r_out_valid && !m_axis_tready) |=> (r_state == ST_ACC))
        else $error("accumulate step left with output busy");

    // an accepted word starts the memory read
    a_accept_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == ST_LOOK))
        else $error("accepted word did not start the sequence");

endmodule

// File: design/plq_ram.sv
// ----------------------------------------------------------------------------
// plq_ram: generic single write, single read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module plq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/plq_agg.sv
// ----------------------------------------------------------------------------
// plq_agg: shared multiply and accumulate unit for the level aggregates
// Forms shares times level price into a product register, then adds it to,
// takes it off or clears the share total and the volume on commit.
// ----------------------------------------------------------------------------
module plq_agg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  plq_pkg::t_agg_ctl              i_ctl,
    input  logic [plq_pkg::PRICE_W-1:0]    i_level_price,
    output logic [plq_pkg::LSHARE_W-1:0]   o_shares,
    output logic [plq_pkg::VOL_W-1:0]      o_volume,
    output logic [plq_pkg::LSHARE_W-1:0]   o_next_shares,
    output logic [plq_pkg::VOL_W-1:0]      o_next_volume
);
    import plq_pkg::*;

    logic [VOL_W-1:0]    r_prod;
    logic [VOL_W-1:0]    w_prod;
    logic [LSHARE_W-1:0] r_shares;
    logic [LSHARE_W-1:0] n_shares;
    logic [VOL_W-1:0]    r_volume;
    logic [VOL_W-1:0]    n_volume;

    // 32 x 32 product, registered before the accumulator
    assign w_prod = {{(VOL_W-SHARE_W){1'b0}}, i_ctl.sh}
                  * {{(VOL_W-PRICE_W){1'b0}}, i_level_price};

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= w_prod;
        end
    end

    // add, take off or clear the aggregates
    always_comb begin
        n_shares = r_shares;
        n_volume = r_volume;
        case (i_ctl.vop)
            VOP_ADD: begin
                n_shares = r_shares + LSHARE_W'(i_ctl.sh);
                n_volume = r_volume + r_prod;
            end
            VOP_SUB: begin
                n_shares = r_shares - LSHARE_W'(i_ctl.sh);
                n_volume = r_volume - r_prod;
            end
            VOP_CLEAR: begin
                n_shares = '0;
                n_volume = '0;
            end
            default: begin
                n_shares = r_shares;
                n_volume = r_volume;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shares <= '0;
            r_volume <= '0;
        end else if (i_ctl.commit) begin
            r_shares <= n_shares;
            r_volume <= n_volume;
        end
    end

    assign o_shares      = r_shares;
    assign o_volume      = r_volume;
    assign o_next_shares = n_shares;
    assign o_next_volume = n_volume;

endmodule

// File: tb/sv/price_level_order_queue_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_level_order_queue_top_tb: self-checking bench for one order book level
// Sends push, pop and remove words with random gaps and output stalls. A
// scoreboard keeps its own linked queue, listed bits and aggregates. It checks
// every result word against the oldest prediction. Between phases the level
// price changes while orders rest, so pop and remove volumes may wrap.
// ----------------------------------------------------------------------------
module price_level_order_queue_top_tb;
    import plq_pkg::*;

    localparam int unsigned SLOTS        = 256;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned HOLD_CYCLES  = 160;
    localparam int unsigned HOLD_AT      = 90;
    localparam int unsigned REPORT_MAX   = 10;
    localparam int unsigned IDLE_PCT     = 26;

    // result word field offsets
    localparam int unsigned OFF_PSH = SLOT_W;
    localparam int unsigned OFF_CNT = OFF_PSH + SHARE_W;
    localparam int unsigned OFF_LSH = OFF_CNT + COUNT_W;
    localparam int unsigned OFF_VOL = OFF_LSH + LSHARE_W;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   pslot;
        logic [SHARE_W-1:0]  pshares;
        logic [COUNT_W-1:0]  orders;
        logic [LSHARE_W-1:0] lshares;
        logic [VOL_W-1:0]    volume;
    } t_level_result;

    // Mirror of the price level: linked queue, listed bits and aggregates
    class level_book;
        logic [PRICE_W-1:0] price;
        logic [SLOT_W-1:0]  next_of [SLOTS];
        logic [SLOT_W-1:0]  prev_of [SLOTS];
        logic [SHARE_W-1:0] held    [SLOTS];
        bit                 listed  [SLOTS];
        logic [SLOT_W-1:0]  head;
        logic [SLOT_W-1:0]  tail;
        int unsigned        resting;
        logic [63:0]        shares_sum;
        logic [VOL_W-1:0]   volume;
        t_level_result      due_results [$];
        int unsigned        mismatches;

        function new();
            price      = '0;
            head       = '0;
            tail       = '0;
            resting    = 0;
            shares_sum = '0;
            volume     = '0;
            mismatches = 0;
            foreach (listed[i]) begin
                listed[i]  = 1'b0;
                next_of[i] = '0;
                prev_of[i] = '0;
                held[i]    = '0;
            end
        endfunction

        // drop a slot from the aggregates; an emptied queue clears them
        function void unlist(logic [SLOT_W-1:0] s);
            logic [63:0] sh;
            sh = {32'd0, held[s]};
            listed[s] = 1'b0;
            if (resting <= 1) begin
                resting    = 0;
                shares_sum = '0;
                volume     = '0;
                head       = '0;
                tail       = '0;
            end else begin
                resting--;
                shares_sum -= sh;
                volume     -= sh * {32'd0, price};
            end
        endfunction

        // apply one accepted operation word and queue its result
        function void take_in_op(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
                                 logic [PRICE_W-1:0] oprice, logic [SHARE_W-1:0] oshares);
            t_level_result r;
            logic [SLOT_W-1:0] t;
            r = '0;
            r.status = STS_OK;
            case (kind)
                KIND_PUSH: begin
                    if (oprice != price) begin
                        r.status = STS_PRICE;
                    end else if (listed[slot]) begin
                        r.status = STS_LISTED;
                    end else begin
                        next_of[slot] = head;
                        prev_of[slot] = '0;
                        if (resting != 0) prev_of[head] = slot;
                        else tail = slot;
                        head         = slot;
                        held[slot]   = oshares;
                        listed[slot] = 1'b1;
                        resting++;
                        shares_sum += {32'd0, oshares};
                        volume     += {32'd0, oshares} * {32'd0, price};
                    end
                end
                KIND_POP: begin
                    if (resting == 0) begin
                        r.status = STS_EMPTY;
                    end else begin
                        t         = tail;
                        r.pslot   = t;
                        r.pshares = held[t];
                        if (resting > 1) tail = prev_of[t];
                        unlist(t);
                    end
                end
                KIND_REMOVE: begin
                    if (!listed[slot] || resting == 0) begin
                        r.status = STS_NOT_LISTED;
                    end else begin
                        // unlink from whichever end or the middle
                        if (resting > 1) begin
                            if (slot == tail) begin
                                tail = prev_of[slot];
                            end else if (slot == head) begin
                                head = next_of[slot];
                            end else begin
                                next_of[prev_of[slot]] = next_of[slot];
                                prev_of[next_of[slot]] = prev_of[slot];
                            end
                        end
                        unlist(slot);
                    end
                end
                default: ;
            endcase
            r.orders  = resting[COUNT_W-1:0];
            r.lshares = shares_sum[LSHARE_W-1:0];
            r.volume  = volume;
            due_results.push_back(r);
        endfunction

        // compare one result word with the oldest prediction
        function void check_word(logic [STATUS_W-1:0] sts, logic [M_TDATA_W-1:0] word);
            t_level_result got;
            t_level_result want;
            got.status  = sts;
            got.pslot   = word[SLOT_W-1:0];
            got.pshares = word[OFF_PSH +: SHARE_W];
            got.orders  = word[OFF_CNT +: COUNT_W];
            got.lshares = word[OFF_LSH +: LSHARE_W];
            got.volume  = word[OFF_VOL +: VOL_W];
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result word: status %0d data %h", sts, word);
                return;
            end
            want = due_results.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("mismatch expected: sts %0d slot %0d sh %0d cnt %0d lvl %0d vol %0d",
                             want.status, want.pslot, want.pshares, want.orders,
                             want.lshares, want.volume);
                    $display("           actual: sts %0d slot %0d sh %0d cnt %0d lvl %0d vol %0d",
                             got.status, got.pslot, got.pshares, got.orders,
                             got.lshares, got.volume);
                end
            end
        endfunction

        // first slot from a given one whose listed bit matches
        function logic [SLOT_W-1:0] nearby_slot(logic [SLOT_W-1:0] from, bit want);
            logic [SLOT_W-1:0] s;
            s = from;
            for (int i = 0; i < SLOTS; i++) begin
                if (listed[s] == want) return s;
                s++;
            end
            return from;
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [PRICE_W-1:0]    i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [KIND_W-1:0]     s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;

    level_book   book = new();
    bit          quiet = 1'b0;
    int unsigned words_in = 0;
    int unsigned stall_cycles = 0;

    price_level_order_queue_top #(
        .ORDER_SLOTS(SLOTS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // note accepted words and check results at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) book.price = i_cfg_data;
            if (s_axis_tvalid && s_axis_tready) begin
                book.take_in_op(s_axis_tuser, s_axis_tdata[SLOT_W-1:0],
                                s_axis_tdata[SLOT_W +: PRICE_W],
                                s_axis_tdata[SLOT_W+PRICE_W +: SHARE_W]);
                words_in++;
            end
            if (m_axis_tvalid && m_axis_tready) book.check_word(m_axis_tuser, m_axis_tdata);
        end
    end

    // end the run when no word moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off to back the block up
    initial begin : receiver
        int unsigned hold_left;
        bit          held_off;
        hold_left = 0;
        held_off  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!held_off && words_in >= HOLD_AT) begin
                held_off  = 1'b1;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // offer one operation word, with random gaps ahead of it
    task automatic send_op(input logic [KIND_W-1:0] kind, input logic [SLOT_W-1:0] slot,
                           input logic [PRICE_W-1:0] price, input logic [SHARE_W-1:0] shares);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {shares, price, slot};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // write the level price once every result is back
    task automatic write_price(input logic [PRICE_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (book.due_results.size() != 0) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // one random operation, mostly well formed
    task automatic random_op(input int unsigned push_w, input int unsigned pop_w);
        int unsigned        pick;
        logic [KIND_W-1:0]  kind;
        logic [SLOT_W-1:0]  slot;
        logic [PRICE_W-1:0] price;
        logic [SHARE_W-1:0] shares;
        pick  = $urandom_range(0, 99);
        slot  = SLOT_W'($urandom);
        price = $urandom;
        case ($urandom_range(0, 7))
            0:       shares = '0;
            1:       shares = '1;
            2, 3:    shares = $urandom_range(1, 1000);
            default: shares = $urandom;
        endcase
        if (pick < push_w) begin
            kind = KIND_PUSH;
            if ($urandom_range(0, 9) != 0) price = book.price;
            if ($urandom_range(0, 4) != 0) slot = book.nearby_slot(slot, 1'b0);
        end else if (pick < push_w + pop_w) begin
            kind = KIND_POP;
        end else if (pick < 97) begin
            kind = KIND_REMOVE;
            if ($urandom_range(0, 5) != 0) slot = book.nearby_slot(slot, 1'b1);
        end else begin
            kind = KIND_SPARE;
        end
        send_op(kind, slot, price, shares);
    endtask

    // new level price, then a run of random operations
    task automatic run_phase(input logic [PRICE_W-1:0] value, input int unsigned items,
                             input int unsigned push_w, input int unsigned pop_w,
                             input int unsigned quiet_from, input int unsigned quiet_to);
        write_price(value);
        for (int unsigned n = 0; n < items; n++) begin
            quiet = (n >= quiet_from) && (n < quiet_to);
            random_op(push_w, pop_w);
        end
        quiet = 1'b0;
    endtask

    initial begin : stimulus
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_price(32'd1000);

        // empty queue, unlisted remove, price checks ahead of listed check
        send_op(KIND_POP,    8'd0,   32'd0,          32'd0);
        send_op(KIND_REMOVE, 8'd5,   32'd1000,       32'd9);
        send_op(KIND_PUSH,   8'd0,   32'd0,          32'd10);
        send_op(KIND_PUSH,   8'd0,   32'd1000,       32'd0);
        send_op(KIND_PUSH,   8'd0,   32'hFFFF_FFFF,  32'd4);
        send_op(KIND_PUSH,   8'd0,   32'd1000,       32'd4);
        send_op(KIND_PUSH,   8'd255, 32'd1000,       32'hFFFF_FFFF);
        send_op(KIND_PUSH,   8'd17,  32'd1000,       32'd500);
        send_op(KIND_PUSH,   8'd42,  32'd1000,       32'd7);
        send_op(KIND_PUSH,   8'd128, 32'd1000,       32'd1);
        // unlink from the middle, the head and the tail
        send_op(KIND_REMOVE, 8'd17,  32'd0,          32'd0);
        send_op(KIND_REMOVE, 8'd128, 32'd0,          32'd0);
        send_op(KIND_REMOVE, 8'd0,   32'd0,          32'd0);
        send_op(KIND_SPARE,  8'hFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF);
        send_op(KIND_POP,    8'd0,   32'd0,          32'd0);
        send_op(KIND_REMOVE, 8'd42,  32'd0,          32'd0);
        send_op(KIND_REMOVE, 8'd42,  32'd0,          32'd0);
        send_op(KIND_POP,    8'd0,   32'd0,          32'd0);
        send_op(KIND_PUSH,   8'd3,   32'd1000,       32'hFFFF_FFFF);
        send_op(KIND_PUSH,   8'd4,   32'd1000,       32'd12345);
        // price change with orders resting: take-off volume wraps
        write_price(32'hFFFF_FFFF);
        send_op(KIND_POP,    8'd0,   32'd0,          32'd0);
        send_op(KIND_POP,    8'd0,   32'd0,          32'd0);

        // random phases: mixed, fill to the full pool, churn at price zero, drain
        run_phase(32'hFFFF_FFFF, 80,  55, 20, 0,   0);
        run_phase($urandom,      320, 95, 2,  100, 220);
        run_phase(32'd0,         120, 35, 30, 0,   0);
        run_phase($urandom,      130, 20, 45, 0,   0);

        s_axis_tvalid <= 1'b0;
        while (book.due_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (book.mismatches == 0 && book.due_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
